[sv/saml_pkg.sv]
package saml_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LEVEL_BITS = 7;
   localparam int MODE_BITS = 2;
   localparam int INTERVAL_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd100;

   localparam logic OP_NORMAL = 1'b0;
   localparam logic OP_PRIME = 1'b1;

   typedef enum logic [MODE_BITS-1:0] {
      SLEEP_MODE = 2'd0,
      IDLE_MODE = 2'd1,
      ACTIVE_MODE = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_LOW = 3'd0,
      CSR_RANGE_HIGH = 3'd1,
      CSR_CHANGE_THRESHOLD = 3'd2,
      CSR_SLEEP_INTERVAL = 3'd3,
      CSR_IDLE_INTERVAL = 3'd4,
      CSR_ACTIVE_INTERVAL = 3'd5
   } csr_index_type;

   localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RESET = 12'd300;
   localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RESET = 12'd800;
   localparam logic [SAMPLE_BITS-1:0] CHANGE_THRESHOLD_RESET = 12'd8;
   localparam logic [INTERVAL_BITS-1:0] SLEEP_INTERVAL_RESET = 16'd1000;
   localparam logic [INTERVAL_BITS-1:0] IDLE_INTERVAL_RESET = 16'd300;
   localparam logic [INTERVAL_BITS-1:0] ACTIVE_INTERVAL_RESET = 16'd100;

endpackage

[sv/saml_req_if.sv]
interface saml_req_if import saml_pkg::*; ();
   logic valid;
   logic ready;
   logic opcode;
   logic [SAMPLE_BITS-1:0] sample;
   logic connected;

   modport source(output valid, opcode, sample, connected, input ready);
   modport sink(input valid, opcode, sample, connected, output ready);
endinterface

[sv/saml_rsp_if.sv]
interface saml_rsp_if import saml_pkg::*; ();
   logic valid;
   logic ready;
   logic [SAMPLE_BITS-1:0] average;
   logic [LEVEL_BITS-1:0] level;
   logic [MODE_BITS-1:0] mode;
   logic [INTERVAL_BITS-1:0] interval_ms;
   logic send;

   modport source(output valid, average, level, mode, interval_ms, send, input ready);
   modport sink(input valid, average, level, mode, interval_ms, send, output ready);
endinterface

[sv/saml_csr_if.sv]
interface saml_csr_if import saml_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[sv/sensor_average_level_mode.sv]
// Moving average over the last WINDOW_LEN sensor samples, mapped linearly onto a
// 0..100 level between range_low and range_high, with a sleep/idle/active mode and
// that mode's sample interval. One request gives one response. Each request passes
// through a registered ring memory read, a bit-serial divide by WINDOW_LEN at one
// quotient bit per cycle, a map and a multiply step, a bit-serial level divide of
// seven quotient bits, a load of the response register, which waits while a
// previous response is held and not yet taken, and the idle state in which the next
// request is taken. A new request is taken while the previous response still waits.
// A prime request fills the window with its sample at once; there is no clearing pass.
// Configuration writes are taken every cycle and belong between requests.
module sensor_average_level_mode import saml_pkg::*; #(
   parameter int WINDOW_LEN = 10
) (
   input logic clock,
   input logic reset,
   saml_req_if.sink req_chan,
   saml_rsp_if.source rsp_chan,
   saml_csr_if.sink csr_chan
);

   localparam int PW = $clog2(WINDOW_LEN);
   localparam int SW = SAMPLE_BITS + $clog2(WINDOW_LEN);
   localparam int RW = $clog2(WINDOW_LEN) + 1;
   localparam int CW = $clog2(SW + 1);
   localparam int NW = SAMPLE_BITS + LEVEL_BITS;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_DIV = 7'b0000100,
      S_MAP = 7'b0001000,
      S_MUL = 7'b0010000,
      S_LDIV = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] range_low_ff, range_high_ff, threshold_ff;
   logic [INTERVAL_BITS-1:0] sleep_iv_ff, idle_iv_ff, active_iv_ff;

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [SAMPLE_BITS-1:0] fill_ff;
   logic [PW-1:0] pos_ff;
   logic [SW-1:0] sum_ff;
   logic [SAMPLE_BITS-1:0] prev_ff;

   logic prime_ff, conn_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;

   logic [SW-1:0] dq_ff, dq_in;
   logic [RW-2:0] drem_ff, drem_in;
   logic [CW-1:0] cnt_ff;

   logic [SAMPLE_BITS-1:0] span_ff, diff_ff;
   logic lzero_ff, lfull_ff;
   logic [SAMPLE_BITS-1:0] lrem_ff, lrem_in;
   logic [LEVEL_BITS-1:0] lq_ff, lq_in;

   logic rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_avg_ff;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic [MODE_BITS-1:0] rsp_mode_ff;
   logic [INTERVAL_BITS-1:0] rsp_iv_ff;
   logic rsp_send_ff;

   logic req_fire, rsp_fire, load_rsp;
   logic [SAMPLE_BITS-1:0] old_smp, avg;
   logic [SW-1:0] sum_in;
   logic [RW-1:0] dtrial;
   logic [SAMPLE_BITS:0] ltrial;
   logic [NW-1:0] lnum;
   logic [SAMPLE_BITS-1:0] delta;
   logic [LEVEL_BITS-1:0] level;
   mode_type mode;
   logic [INTERVAL_BITS-1:0] interval;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.average = rsp_avg_ff;
   assign rsp_chan.level = rsp_level_ff;
   assign rsp_chan.mode = rsp_mode_ff;
   assign rsp_chan.interval_ms = rsp_iv_ff;
   assign rsp_chan.send = rsp_send_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
         threshold_ff <= CHANGE_THRESHOLD_RESET;
         sleep_iv_ff <= SLEEP_INTERVAL_RESET;
         idle_iv_ff <= IDLE_INTERVAL_RESET;
         active_iv_ff <= ACTIVE_INTERVAL_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_RANGE_LOW: range_low_ff <= csr_chan.data[SAMPLE_BITS-1:0];
            CSR_RANGE_HIGH: range_high_ff <= csr_chan.data[SAMPLE_BITS-1:0];
            CSR_CHANGE_THRESHOLD: threshold_ff <= csr_chan.data[SAMPLE_BITS-1:0];
            CSR_SLEEP_INTERVAL: sleep_iv_ff <= csr_chan.data;
            CSR_IDLE_INTERVAL: idle_iv_ff <= csr_chan.data;
            CSR_ACTIVE_INTERVAL: active_iv_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= ring_mem[pos_ff];
      end
      if (state_ff == S_READ && !prime_ff) begin
         ring_mem[pos_ff] <= smp_ff;
      end
   end

   // entries not written since the last prime read as the prime value
   assign old_smp = valid_ff[pos_ff] ? rd_ff : fill_ff;
   assign sum_in = prime_ff ? SW'(smp_ff) * SW'(WINDOW_LEN)
                            : sum_ff - SW'(old_smp) + SW'(smp_ff);

   // restoring divide by the window length, one quotient bit a cycle
   assign dtrial = {drem_ff, dq_ff[SW-1]};
   always_comb begin
      if (dtrial >= RW'(WINDOW_LEN)) begin
         drem_in = (RW-1)'(dtrial - RW'(WINDOW_LEN));
         dq_in = {dq_ff[SW-2:0], 1'b1};
      end else begin
         drem_in = dtrial[RW-2:0];
         dq_in = {dq_ff[SW-2:0], 1'b0};
      end
   end
   assign avg = dq_ff[SAMPLE_BITS-1:0];

   // level: (avg - low) * 100 / span, seven quotient bits
   assign lnum = NW'(diff_ff) * NW'(LEVEL_MAX);
   assign ltrial = {lrem_ff, lq_ff[LEVEL_BITS-1]};
   always_comb begin
      if (ltrial >= {1'b0, span_ff}) begin
         lrem_in = SAMPLE_BITS'(ltrial - {1'b0, span_ff});
         lq_in = {lq_ff[LEVEL_BITS-2:0], 1'b1};
      end else begin
         lrem_in = ltrial[SAMPLE_BITS-1:0];
         lq_in = {lq_ff[LEVEL_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      if (lzero_ff) begin
         level = '0;
      end else if (lfull_ff) begin
         level = LEVEL_MAX;
      end else begin
         level = lq_ff;
      end
      if (prime_ff) begin
         delta = '0;
      end else if (avg >= prev_ff) begin
         delta = avg - prev_ff;
      end else begin
         delta = prev_ff - avg;
      end
      if (!conn_ff) begin
         mode = SLEEP_MODE;
         interval = sleep_iv_ff;
      end else if (delta >= threshold_ff) begin
         mode = ACTIVE_MODE;
         interval = active_iv_ff;
      end else begin
         mode = IDLE_MODE;
         interval = idle_iv_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_READ;
         S_READ: state_in = S_DIV;
         S_DIV: if (cnt_ff == CW'(SW - 1)) state_in = S_MAP;
         S_MAP: state_in = S_MUL;
         S_MUL: state_in = S_LDIV;
         S_LDIV: if (cnt_ff == CW'(LEVEL_BITS - 1)) state_in = S_DONE;
         S_DONE: if (load_rsp) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         fill_ff <= '0;
         pos_ff <= '0;
         sum_ff <= '0;
         prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_READ: begin
               sum_ff <= sum_in;
               cnt_ff <= '0;
               if (prime_ff) begin
                  valid_ff <= '0;
                  fill_ff <= smp_ff;
                  pos_ff <= '0;
               end else begin
                  valid_ff[pos_ff] <= 1'b1;
                  pos_ff <= (pos_ff == PW'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
               end
            end
            S_DIV: cnt_ff <= (cnt_ff == CW'(SW - 1)) ? '0 : cnt_ff + 1'b1;
            S_LDIV: cnt_ff <= cnt_ff + 1'b1;
            S_DONE: if (load_rsp) prev_ff <= avg;
            default: ;
         endcase
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         prime_ff <= (req_chan.opcode == OP_PRIME);
         smp_ff <= req_chan.sample;
         conn_ff <= req_chan.connected;
      end
      case (state_ff)
         S_READ: begin
            dq_ff <= sum_in;
            drem_ff <= '0;
         end
         S_DIV: begin
            dq_ff <= dq_in;
            drem_ff <= drem_in;
         end
         S_MAP: begin
            span_ff <= range_high_ff - range_low_ff;
            diff_ff <= avg - range_low_ff;
            lzero_ff <= (range_high_ff <= range_low_ff) || (avg <= range_low_ff);
            lfull_ff <= (avg - range_low_ff) >= (range_high_ff - range_low_ff);
         end
         S_MUL: begin
            lrem_ff <= lnum[NW-1:LEVEL_BITS];
            lq_ff <= lnum[LEVEL_BITS-1:0];
         end
         S_LDIV: begin
            lrem_ff <= lrem_in;
            lq_ff <= lq_in;
         end
         default: ;
      endcase
      if (load_rsp) begin
         rsp_avg_ff <= avg;
         rsp_level_ff <= level;
         rsp_mode_ff <= mode;
         rsp_iv_ff <= interval;
         rsp_send_ff <= !prime_ff && conn_ff;
      end
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= LEVEL_MAX)
      else $error("level above full scale");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(WINDOW_LEN - 1))
      else $error("ring position out of window");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SW'(WINDOW_LEN) * SW'({SAMPLE_BITS{1'b1}}))
      else $error("running sum exceeds window maximum");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("request accepted without ring read");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

endmodule
